// ===== hdl/cms_pkg.sv =====
package cms_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 24;
    localparam int FRAC_W      = 8;
    localparam int SCALE_W     = 16;
    localparam int FLAG_W      = 4;

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int MAG_W  = SAMPLE_BITS + CNT_W;
    localparam int DEV_W  = SAMPLE_BITS + CNT_W + 2;
    localparam int SS_W   = 2 * MAG_W + AW;
    localparam int DVD_W  = SS_W + SCALE_W;
    localparam int DVS_W  = 3 * CNT_W;
    localparam int RT_W   = OUT_W;
    localparam int RAD_W  = 2 * OUT_W;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam int SCNT_W = $clog2(RT_W + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP1,
        ST_PREP2,
        ST_MEAN_A,
        ST_MEAN_K,
        ST_SQ_RD,
        ST_SQ_DEV,
        ST_SQ_MUL,
        ST_DIV_S,
        ST_ROOT_S,
        ST_DIV_K,
        ST_ROOT_K,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic            done;
        logic [RT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// ===== hdl/cms_div.sv =====
module cms_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cms_pkg::div_req_t  req,
    output cms_pkg::div_rsp_t  rsp
);

    logic [cms_pkg::DCNT_W-1:0] cnt_reg;
    logic                       done_reg;
    logic [cms_pkg::DVD_W-1:0]  dvd_reg;
    logic [cms_pkg::DVS_W-1:0]  dvs_reg;
    logic [cms_pkg::DVS_W-1:0]  rem_reg;
    logic [cms_pkg::DVS_W:0]    rem2;
    logic                       ge;
    logic [cms_pkg::DVS_W-1:0]  rem_next;

    assign rem2     = {rem_reg, dvd_reg[cms_pkg::DVD_W-1]};
    assign ge       = rem2 >= {1'b0, dvs_reg};
    assign rem_next = ge ? cms_pkg::DVS_W'(rem2 - {1'b0, dvs_reg})
                         : cms_pkg::DVS_W'(rem2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= cms_pkg::DCNT_W'(cms_pkg::DVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == cms_pkg::DCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[cms_pkg::DVD_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;

endmodule

// ===== hdl/cms_sqrt.sv =====
module cms_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  cms_pkg::sqrt_req_t  req,
    output cms_pkg::sqrt_rsp_t  rsp
);

    logic [cms_pkg::SCNT_W-1:0] cnt_reg;
    logic                       done_reg;
    logic [cms_pkg::RAD_W-1:0]  rad_reg;
    logic [cms_pkg::RT_W-1:0]   root_reg;
    logic [cms_pkg::RT_W:0]     rem_reg;
    logic [cms_pkg::RT_W+2:0]   rem2;
    logic [cms_pkg::RT_W+2:0]   trial;
    logic                       ge;

    assign rem2  = {rem_reg, rad_reg[cms_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= cms_pkg::SCNT_W'(cms_pkg::RT_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == cms_pkg::SCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[cms_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (cms_pkg::RT_W+1)'(rem2 - trial) : (cms_pkg::RT_W+1)'(rem2);
            root_reg <= {root_reg[cms_pkg::RT_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

// ===== hdl/column_mean_stddev.sv =====
// Column statistics. Words of one column arrive on the slave side, one signed sample per
// word, with tlast on the final one; a load takes one word per cycle and up to 1024 values
// are stored (later ones are dropped and flagged). After tlast the block stops taking words
// and makes an end pass: divisor setup, up to two divisions for the means, then per stored
// value, if there are two or more, a read, a deviation step and a bit-serial squaring, then
// per deviation result a division and, unless its quotient is too large (result saturated),
// a root. One result word follows on the master side and the block returns to loading; if an
// earlier result still waits in the output register, hold until it is taken.
module column_mean_stddev (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cms_pkg::IN_W-1:0]          s_tdata,   // sample
    input  logic                              s_tlast,   // last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [4*cms_pkg::OUT_W-1:0]       m_tdata,   // mean_all, mean_nonzero,
                                                         // std_sample, std_nonzero
    output logic [cms_pkg::FLAG_W-1:0]        m_tuser    // nonzero_valid, std_sample_valid,
                                                         // std_nonzero_valid, overflowed
);

    cms_pkg::state_t state_reg, state_next;

    logic [cms_pkg::SAMPLE_BITS-1:0] mem [cms_pkg::MAX_POINTS];
    logic [cms_pkg::SAMPLE_BITS-1:0] rd_data_reg;

    logic [cms_pkg::CNT_W-1:0]       cnt_reg;
    logic [cms_pkg::CNT_W-1:0]       nzc_reg;
    logic signed [cms_pkg::SUM_W-1:0] sum_reg;
    logic                            ovf_reg;
    logic                            launched_reg;
    logic                            m_valid_reg;
    logic [4*cms_pkg::OUT_W-1:0]     m_data_reg;
    logic [cms_pkg::FLAG_W-1:0]      m_user_reg;

    logic [cms_pkg::CNT_W-1:0]       idx_reg;
    logic [2*cms_pkg::CNT_W-1:0]     nn_reg;
    logic [cms_pkg::DVS_W-1:0]       ds_reg;
    logic [cms_pkg::DVS_W-1:0]       dk_reg;
    logic                            neg_reg;
    logic [cms_pkg::SUM_W-1:0]       abs_reg;
    logic [cms_pkg::SS_W-1:0]        mcand_reg;
    logic [cms_pkg::MAG_W-1:0]       mplier_reg;
    logic [cms_pkg::SS_W-1:0]        ss_reg;
    logic [cms_pkg::OUT_W-1:0]       mean_a_reg;
    logic [cms_pkg::OUT_W-1:0]       mean_k_reg;
    logic [cms_pkg::OUT_W-1:0]       std_s_reg;
    logic [cms_pkg::OUT_W-1:0]       std_k_reg;

    logic                            accept;
    logic                            full;
    logic signed [cms_pkg::SAMPLE_BITS-1:0] x_in;
    logic                            div_go;
    logic                            sqrt_go;
    logic                            out_load;
    logic                            big;
    logic                            one_val;
    logic                            no_nz;
    logic                            last_idx;
    logic [cms_pkg::OUT_W-1:0]       q_low;
    logic [cms_pkg::OUT_W-1:0]       q_sgn;
    logic signed [cms_pkg::DEV_W-1:0] prod_w;
    logic signed [cms_pkg::DEV_W-1:0] dev;
    logic [cms_pkg::MAG_W-1:0]       mag;

    cms_pkg::div_req_t  div_req;
    cms_pkg::div_rsp_t  div_rsp;
    cms_pkg::sqrt_req_t sqrt_req;
    cms_pkg::sqrt_rsp_t sqrt_rsp;

    assign x_in     = s_tdata[cms_pkg::SAMPLE_BITS-1:0];
    assign accept   = s_tvalid && s_tready;
    assign full     = cnt_reg == cms_pkg::CNT_W'(cms_pkg::MAX_POINTS);
    assign one_val  = cnt_reg == cms_pkg::CNT_W'(1);
    assign no_nz    = nzc_reg == '0;
    assign last_idx = cms_pkg::CNT_W'(idx_reg + 1'b1) == cnt_reg;
    assign big      = |div_rsp.quot[cms_pkg::DVD_W-1:cms_pkg::RAD_W];
    assign q_low    = div_rsp.quot[cms_pkg::OUT_W-1:0];
    assign q_sgn    = neg_reg ? -q_low : q_low;

    assign prod_w = cms_pkg::DEV_W'($signed(rd_data_reg))
                  * cms_pkg::DEV_W'($signed({1'b0, cnt_reg}));
    assign dev    = prod_w - cms_pkg::DEV_W'(sum_reg);
    assign mag    = cms_pkg::MAG_W'(dev[cms_pkg::DEV_W-1] ? -dev : dev);

    cms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    cms_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cms_pkg::ST_LOAD:
                if (accept && s_tlast)
                    state_next = cms_pkg::ST_PREP1;
            cms_pkg::ST_PREP1:
                state_next = cms_pkg::ST_PREP2;
            cms_pkg::ST_PREP2:
                state_next = cms_pkg::ST_MEAN_A;
            cms_pkg::ST_MEAN_A:
                if (div_rsp.done)
                begin
                    if (one_val)
                        state_next = cms_pkg::ST_FINISH;
                    else if (no_nz)
                        state_next = cms_pkg::ST_SQ_RD;
                    else
                        state_next = cms_pkg::ST_MEAN_K;
                end
            cms_pkg::ST_MEAN_K:
                if (div_rsp.done)
                    state_next = cms_pkg::ST_SQ_RD;
            cms_pkg::ST_SQ_RD:
                state_next = cms_pkg::ST_SQ_DEV;
            cms_pkg::ST_SQ_DEV:
                state_next = cms_pkg::ST_SQ_MUL;
            cms_pkg::ST_SQ_MUL:
                if (mplier_reg == '0)
                    state_next = last_idx ? cms_pkg::ST_DIV_S : cms_pkg::ST_SQ_RD;
            cms_pkg::ST_DIV_S:
                if (div_rsp.done)
                begin
                    if (!big)
                        state_next = cms_pkg::ST_ROOT_S;
                    else
                        state_next = no_nz ? cms_pkg::ST_FINISH : cms_pkg::ST_DIV_K;
                end
            cms_pkg::ST_ROOT_S:
                if (sqrt_rsp.done)
                    state_next = no_nz ? cms_pkg::ST_FINISH : cms_pkg::ST_DIV_K;
            cms_pkg::ST_DIV_K:
                if (div_rsp.done)
                    state_next = big ? cms_pkg::ST_FINISH : cms_pkg::ST_ROOT_K;
            cms_pkg::ST_ROOT_K:
                if (sqrt_rsp.done)
                    state_next = cms_pkg::ST_FINISH;
            cms_pkg::ST_FINISH:
                if (!m_valid_reg || m_tready)
                    state_next = cms_pkg::ST_LOAD;
            default:
                state_next = cms_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        s_tready          = 1'b0;
        div_go            = 1'b0;
        sqrt_go           = 1'b0;
        out_load          = 1'b0;
        div_req.dividend  = cms_pkg::DVD_W'({abs_reg, cms_pkg::FRAC_W'(0)});
        div_req.divisor   = cms_pkg::DVS_W'(cnt_reg);
        unique case (state_reg) inside
            cms_pkg::ST_LOAD:
                s_tready = 1'b1;
            cms_pkg::ST_MEAN_A:
                div_go = !launched_reg;
            cms_pkg::ST_MEAN_K:
            begin
                div_go          = !launched_reg;
                div_req.divisor = cms_pkg::DVS_W'(nzc_reg);
            end
            cms_pkg::ST_DIV_S:
            begin
                div_go           = !launched_reg;
                div_req.dividend = {ss_reg, cms_pkg::SCALE_W'(0)};
                div_req.divisor  = ds_reg;
            end
            cms_pkg::ST_DIV_K:
            begin
                div_go           = !launched_reg;
                div_req.dividend = {ss_reg, cms_pkg::SCALE_W'(0)};
                div_req.divisor  = dk_reg;
            end
            cms_pkg::ST_ROOT_S, cms_pkg::ST_ROOT_K:
                sqrt_go = !launched_reg;
            cms_pkg::ST_FINISH:
                out_load = !m_valid_reg || m_tready;
            default:
                s_tready = 1'b0;
        endcase
        div_req.start     = div_go;
        sqrt_req.start    = sqrt_go;
        sqrt_req.radicand = div_rsp.quot[cms_pkg::RAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cms_pkg::ST_LOAD;
            cnt_reg      <= '0;
            nzc_reg      <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            launched_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_go || sqrt_go)
                launched_reg <= 1'b1;
            else if (div_rsp.done || sqrt_rsp.done)
                launched_reg <= 1'b0;
            if (accept)
            begin
                if (!full)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sum_reg <= sum_reg + cms_pkg::SUM_W'(x_in);
                    if (x_in != '0)
                        nzc_reg <= nzc_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                cnt_reg     <= '0;
                nzc_reg     <= '0;
                sum_reg     <= '0;
                ovf_reg     <= 1'b0;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !full)
            mem[cnt_reg[cms_pkg::AW-1:0]] <= x_in;
        rd_data_reg <= mem[idx_reg[cms_pkg::AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            cms_pkg::ST_PREP1:
            begin
                nn_reg  <= (2*cms_pkg::CNT_W)'(cnt_reg) * (2*cms_pkg::CNT_W)'(cnt_reg);
                neg_reg <= sum_reg[cms_pkg::SUM_W-1];
                abs_reg <= sum_reg[cms_pkg::SUM_W-1] ? cms_pkg::SUM_W'(-sum_reg)
                                                     : cms_pkg::SUM_W'(sum_reg);
            end
            cms_pkg::ST_PREP2:
            begin
                ds_reg <= cms_pkg::DVS_W'(nn_reg) * cms_pkg::DVS_W'(cnt_reg - 1'b1);
                dk_reg <= cms_pkg::DVS_W'(nn_reg) * cms_pkg::DVS_W'(nzc_reg);
            end
            cms_pkg::ST_MEAN_A:
                if (div_rsp.done)
                begin
                    mean_a_reg <= q_sgn;
                    idx_reg    <= '0;
                    ss_reg     <= '0;
                    std_s_reg  <= '0;
                    if (one_val)
                    begin
                        mean_k_reg <= q_sgn;
                        std_k_reg  <= '0;
                    end
                    else if (no_nz)
                    begin
                        mean_k_reg <= '0;
                        std_k_reg  <= '0;
                    end
                end
            cms_pkg::ST_MEAN_K:
                if (div_rsp.done)
                    mean_k_reg <= q_sgn;
            cms_pkg::ST_SQ_DEV:
            begin
                mplier_reg <= mag;
                mcand_reg  <= cms_pkg::SS_W'(mag);
            end
            cms_pkg::ST_SQ_MUL:
            begin
                if (mplier_reg[0])
                    ss_reg <= ss_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[cms_pkg::SS_W-2:0], 1'b0};
                mplier_reg <= mplier_reg >> 1;
                if (mplier_reg == '0)
                    idx_reg <= idx_reg + 1'b1;
            end
            cms_pkg::ST_DIV_S:
                if (div_rsp.done && big)
                    std_s_reg <= '1;
            cms_pkg::ST_ROOT_S:
                if (sqrt_rsp.done)
                    std_s_reg <= sqrt_rsp.root;
            cms_pkg::ST_DIV_K:
                if (div_rsp.done && big)
                    std_k_reg <= '1;
            cms_pkg::ST_ROOT_K:
                if (sqrt_rsp.done)
                    std_k_reg <= sqrt_rsp.root;
            default:
                idx_reg <= idx_reg;
        endcase
        if (out_load)
        begin
            m_data_reg <= {std_k_reg, std_s_reg, mean_k_reg, mean_a_reg};
            m_user_reg <= {ovf_reg,
                           !one_val && !no_nz,
                           !one_val,
                           one_val || !no_nz};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hdl/cms_chk.sv =====
module cms_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [3:0]  m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_std_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[71:48] == 24'd0 && m_tdata[95:72] == 24'd0
                                    && m_tuser[2] == 1'b0)
        else $error("deviation set without two values");

    a_nz_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[47:24] == 24'd0 && m_tdata[95:72] == 24'd0)
        else $error("nonzero fields set without nonzero values");

endmodule

bind column_mean_stddev cms_chk u_cms_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
